FILE: rtl/core/bsa_pkg.sv
// Shared constants, opcodes and result metadata type for the byte stack allocator.
package bsa_pkg;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned MAX_BLOCK = 64;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned FILL_W    = 9;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned BYTE_W    = 8;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_ALLOC = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic              from_mem;
    logic              last;
    logic              ok;
    logic [FILL_W-1:0] offset;
    logic [FILL_W-1:0] fill;
  } res_meta_t;

endpackage

FILE: rtl/core/bsa_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module bsa_ram #(
  parameter int unsigned DEPTH_P = 256,
  parameter int unsigned WIDTH_P = 8,
  localparam int unsigned AW     = $clog2(DEPTH_P)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [WIDTH_P-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [WIDTH_P-1:0] rdata_o
);

  logic [WIDTH_P-1:0] mem_q [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bsa_ctrl.sv
// Fill pointer, capacity register, pop sequencer and read-stage metadata.
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              cfg_valid_i,
  input  logic [FILL_W-1:0] cfg_capacity_i,
  output logic              s1_valid_o,
  output res_meta_t         s1_meta_o,
  input  logic              s1_take_i,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [BYTE_W-1:0] wdata_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_o
);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] cap_q;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              s1_valid_q, s1_valid_d;
  res_meta_t         meta_q, meta_d;

  logic [FILL_W-1:0] cap_eff;
  logic              s1_free;
  logic              seq_busy;
  logic              accept;
  logic              issue;
  logic [CNT_W-1:0]  cnt_clamp;
  logic [CNT_W-1:0]  pop_n;
  logic [FILL_W-1:0] fill_pop;
  op_e               op;

  assign op        = op_e'(opcode_i);
  assign cap_eff   = (cap_q > FILL_W'(DEPTH)) ? FILL_W'(DEPTH) : cap_q;
  assign s1_free   = !s1_valid_q || s1_take_i;
  assign seq_busy  = (rem_q != '0);
  assign in_stall_o = seq_busy || !s1_free;
  assign accept    = in_valid_i && !in_stall_o;
  assign cnt_clamp = (count_i > CNT_W'(MAX_BLOCK)) ? CNT_W'(MAX_BLOCK) : count_i;
  assign pop_n     = (FILL_W'(cnt_clamp) > fill_q) ? fill_q[CNT_W-1:0] : cnt_clamp;
  assign fill_pop  = fill_q - FILL_W'(pop_n);

  always_comb begin
    fill_d  = fill_q;
    rem_d   = rem_q;
    addr_d  = addr_q;
    issue   = 1'b0;
    meta_d  = meta_q;
    we_o    = 1'b0;
    waddr_o = fill_q[ADDR_W-1:0];
    wdata_o = data_byte_i;
    re_o    = 1'b0;
    raddr_o = addr_q;
    if (seq_busy && s1_free) begin
      issue           = 1'b1;
      re_o            = 1'b1;
      raddr_o         = addr_q;
      addr_d          = addr_q + 1'b1;
      rem_d           = rem_q - 1'b1;
      meta_d.from_mem = 1'b1;
      meta_d.last     = (rem_q == CNT_W'(1));
      meta_d.ok       = 1'b1;
      meta_d.offset   = '0;
      meta_d.fill     = fill_q;
    end else if (accept) begin
      issue           = 1'b1;
      meta_d.from_mem = 1'b0;
      meta_d.last     = 1'b1;
      meta_d.ok       = 1'b0;
      meta_d.offset   = '0;
      unique case (op)
        OP_PUSH: begin
          if (fill_q < cap_eff) begin
            we_o      = 1'b1;
            fill_d    = fill_q + 1'b1;
            meta_d.ok = 1'b1;
          end
        end
        OP_POP: begin
          if (pop_n != '0) begin
            fill_d          = fill_pop;
            re_o            = 1'b1;
            raddr_o         = fill_pop[ADDR_W-1:0];
            addr_d          = fill_pop[ADDR_W-1:0] + 1'b1;
            rem_d           = pop_n - 1'b1;
            meta_d.from_mem = 1'b1;
            meta_d.ok       = 1'b1;
            meta_d.last     = (pop_n == CNT_W'(1));
          end
        end
        OP_ALLOC: begin
          if (fill_q <= cap_eff && (cap_eff - fill_q) >= FILL_W'(count_i)) begin
            fill_d        = fill_q + FILL_W'(count_i);
            meta_d.ok     = 1'b1;
            meta_d.offset = fill_q;
          end
        end
        OP_CLEAR: begin
          fill_d = '0;
        end
        default: begin
          fill_d = fill_q;
        end
      endcase
      meta_d.fill = fill_d;
    end
  end

  assign s1_valid_d = issue || (s1_valid_q && !s1_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      cap_q      <= FILL_W'(256);
      rem_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      rem_q      <= rem_d;
      s1_valid_q <= s1_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_capacity_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    if (issue) begin
      meta_q <= meta_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_meta_o  = meta_q;

endmodule

FILE: rtl/core/bsa_out.sv
// Output register that joins read data with result metadata and holds it under stall.
module bsa_out
  import bsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s1_valid_i,
  input  res_meta_t         s1_meta_i,
  input  logic [BYTE_W-1:0] rdata_i,
  output logic              s1_take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_of_run_o,
  output logic              ok_o,
  output logic [FILL_W-1:0] offset_o,
  output logic [FILL_W-1:0] fill_level_o
);

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic              ok_q;
  logic [FILL_W-1:0] offset_q;
  logic [FILL_W-1:0] fill_q;

  assign s1_take_o   = s1_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = s1_take_o || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take_o) begin
      byte_q   <= s1_meta_i.from_mem ? rdata_i : '0;
      last_q   <= s1_meta_i.last;
      ok_q     <= s1_meta_i.ok;
      offset_q <= s1_meta_i.offset;
      fill_q   <= s1_meta_i.fill;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign ok_o          = ok_q;
  assign offset_o      = offset_q;
  assign fill_level_o  = fill_q;

endmodule

FILE: rtl/core/byte_stack_allocator_top.sv
// Top level of the byte stack allocator: control, byte store and output register.
// Push, allocate and clear each give one result beat; a pop of n bytes gives n beats and holds
// off the next input until its last read is issued, as the byte store has one read port with
// registered read data and delivers one byte per cycle while the output is not stalled. Results
// pass through a read stage and an output register, so a new input is taken while an earlier
// result still waits on a stalled output. The store needs no clearing pass after reset.
module byte_stack_allocator_top
  import bsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [FILL_W-1:0] cfg_capacity_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_of_run_o,
  output logic              ok_o,
  output logic [FILL_W-1:0] offset_o,
  output logic [FILL_W-1:0] fill_level_o
);

  logic              s1_valid;
  res_meta_t         s1_meta;
  logic              s1_take;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  bsa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .data_byte_i    (data_byte_i),
    .count_i        (count_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_capacity_i (cfg_capacity_i),
    .s1_valid_o     (s1_valid),
    .s1_meta_o      (s1_meta),
    .s1_take_i      (s1_take),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .re_o           (re),
    .raddr_o        (raddr)
  );

  bsa_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (BYTE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bsa_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid),
    .s1_meta_i     (s1_meta),
    .rdata_i       (rdata),
    .s1_take_o     (s1_take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .ok_o          (ok_o),
    .offset_o      (offset_o),
    .fill_level_o  (fill_level_o)
  );

endmodule

FILE: rtl/core/bsa_checker.sv
// Port-level assertions for the byte stack allocator and their binding to the top level.
module bsa_checker
  import bsa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BYTE_W-1:0] out_byte_o,
  input logic              last_of_run_o,
  input logic              ok_o,
  input logic [FILL_W-1:0] offset_o,
  input logic [FILL_W-1:0] fill_level_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(fill_level_o))
    else $error("Stalled output beat changed.");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> out_byte_o == '0 && offset_o == '0 && last_of_run_o)
    else $error("Failed result carries data or is not last.");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_level_o <= FILL_W'(DEPTH))
    else $error("Fill level exceeds the store depth.");

  a_run_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> ok_o && offset_o == '0)
    else $error("Non-final beat is not a popped byte.");

endmodule

bind byte_stack_allocator_top bsa_checker u_bsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o),
  .ok_o          (ok_o),
  .offset_o      (offset_o),
  .fill_level_o  (fill_level_o)
);

FILE: tb/byte_stack_allocator_top_tb.sv
// Self-checking testbench for the byte stack allocator: a directed table, then random phases.
`timescale 1ns / 100ps

module byte_stack_allocator_top_tb;
  import bsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              ok;
    logic [FILL_W-1:0] offset;
    logic [FILL_W-1:0] fill;
  } beat_t;

  typedef enum logic {
    ROW_OP,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
    logic [FILL_W-1:0] cap;
    bit                typed;
    logic              ok;
    logic [FILL_W-1:0] offset;
    logic [FILL_W-1:0] fill;
  } row_t;

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [1:0]        opcode_i       = OP_CLEAR;
  logic [BYTE_W-1:0] data_byte_i    = '0;
  logic [CNT_W-1:0]  count_i        = '0;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [FILL_W-1:0] cfg_capacity_i = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [BYTE_W-1:0] out_byte_o;
  logic              last_of_run_o;
  logic              ok_o;
  logic [FILL_W-1:0] offset_o;
  logic [FILL_W-1:0] fill_level_o;

  logic [BYTE_W-1:0] stack_mem [DEPTH];
  bit                mem_written [DEPTH];
  int unsigned       stack_fill;
  int unsigned       cap_reg;
  beat_t             awaited_beats [$];
  int unsigned       fail_count;
  int unsigned       cycle_count;
  bit                quiet;

  byte_stack_allocator_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .data_byte_i    (data_byte_i),
    .count_i        (count_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .ok_o           (ok_o),
    .offset_o       (offset_o),
    .fill_level_o   (fill_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("byte_stack_allocator_top_tb failed");
      $finish;
    end
  end

  task automatic queue_beat(input logic [BYTE_W-1:0] b, input logic last, input logic ok,
                            input logic [FILL_W-1:0] off);
    beat_t bt;
    bt.out_byte = b;
    bt.last     = last;
    bt.ok       = ok;
    bt.offset   = off;
    bt.fill     = stack_fill[FILL_W-1:0];
    awaited_beats.push_back(bt);
  endtask

  task automatic apply_stack_op(input op_e op, input logic [BYTE_W-1:0] data,
                                input logic [CNT_W-1:0] cnt);
    int unsigned eff;
    int unsigned n;
    int unsigned start;
    eff = (cap_reg < DEPTH) ? cap_reg : DEPTH;
    case (op)
      OP_PUSH: begin
        if (stack_fill < eff) begin
          stack_mem[stack_fill]   = data;
          mem_written[stack_fill] = 1'b1;
          stack_fill++;
          queue_beat('0, 1'b1, 1'b1, '0);
        end else begin
          queue_beat('0, 1'b1, 1'b0, '0);
        end
      end
      OP_POP: begin
        n = 32'(cnt);
        if (n > MAX_BLOCK) n = MAX_BLOCK;
        if (n > stack_fill) n = stack_fill;
        if (n == 0) begin
          queue_beat('0, 1'b1, 1'b0, '0);
        end else begin
          stack_fill -= n;
          for (int unsigned k = 0; k < n; k++) begin
            queue_beat(stack_mem[stack_fill + k], k + 1 == n, 1'b1, '0);
          end
        end
      end
      OP_ALLOC: begin
        if (stack_fill <= eff && eff - stack_fill >= 32'(cnt)) begin
          start = stack_fill;
          stack_fill += 32'(cnt);
          queue_beat('0, 1'b1, 1'b1, start[FILL_W-1:0]);
        end else begin
          queue_beat('0, 1'b1, 1'b0, '0);
        end
      end
      default: begin
        stack_fill = 0;
        queue_beat('0, 1'b1, 1'b0, '0);
      end
    endcase
  endtask

  task automatic send_item(input op_e op, input logic [BYTE_W-1:0] data,
                           input logic [CNT_W-1:0] cnt);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_byte_i <= data;
    count_i     <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_stack_op(op, data, cnt);
  endtask

  task automatic sender_gap();
    int unsigned len;
    len = $urandom_range(1, 15);
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    data_byte_i <= BYTE_W'($urandom);
    count_i     <= CNT_W'($urandom);
    repeat (len - 1) @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [FILL_W-1:0] cap);
    drain();
    @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cap_reg = 32'(cap);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Output stall in bursts; the receiver never stalls once the run goes quiet.
  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        hold_cnt = $urandom_range(0, 20);
      end else begin
        out_stall_i <= 1'b1;
        hold_cnt = $urandom_range(0, 14);
      end
    end
  end

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_beats.size() == 0) begin
        $error("unexpected result beat: out_byte %0d fill_level %0d", out_byte_o, fill_level_o);
        fail_count++;
      end else begin
        want = awaited_beats.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %0d, actual %0d", want.out_byte, out_byte_o);
          fail_count++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run_o);
          fail_count++;
        end
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, ok_o);
          fail_count++;
        end
        if (offset_o !== want.offset) begin
          $error("offset: expected %0d, actual %0d", want.offset, offset_o);
          fail_count++;
        end
        if (fill_level_o !== want.fill) begin
          $error("fill_level: expected %0d, actual %0d", want.fill, fill_level_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t              rows [$];
    logic [FILL_W-1:0] phase_cap [PHASES];
    int unsigned       phase_push [PHASES];
    int unsigned       phase_items;
    int unsigned       r;
    int unsigned       rest;
    int unsigned       n;
    int unsigned       safe;
    op_e               op;
    logic [BYTE_W-1:0] d;
    logic [CNT_W-1:0]  c;
    beat_t             typed_beat;

    stack_fill  = 0;
    cap_reg     = 256;
    fail_count  = 0;
    cycle_count = 0;
    quiet       = 1'b0;
    foreach (mem_written[i]) mem_written[i] = 1'b0;

    rows.push_back('{ROW_OP,  OP_POP,   8'h00, 7'd5,   9'd0,   1'b1, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_ALLOC, 8'h00, 7'd0,   9'd0,   1'b1, 1'b1, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_PUSH,  8'h00, 7'd0,   9'd0,   1'b1, 1'b1, 9'd0, 9'd1});
    rows.push_back('{ROW_OP,  OP_PUSH,  8'hFF, 7'd0,   9'd0,   1'b1, 1'b1, 9'd0, 9'd2});
    rows.push_back('{ROW_OP,  OP_PUSH,  8'hA5, 7'd0,   9'd0,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_PUSH,  8'h5A, 7'd0,   9'd0,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_POP,   8'h00, 7'd0,   9'd0,   1'b1, 1'b0, 9'd0, 9'd4});
    rows.push_back('{ROW_OP,  OP_POP,   8'h00, 7'd2,   9'd0,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_POP,   8'h00, 7'd127, 9'd0,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_ALLOC, 8'h00, 7'd127, 9'd0,   1'b1, 1'b1, 9'd0, 9'd127});
    rows.push_back('{ROW_OP,  OP_CLEAR, 8'h00, 7'd0,   9'd0,   1'b1, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_CFG, OP_CLEAR, 8'h00, 7'd0,   9'd0,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_PUSH,  8'h12, 7'd0,   9'd0,   1'b1, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_ALLOC, 8'h00, 7'd0,   9'd0,   1'b1, 1'b1, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_ALLOC, 8'h00, 7'd1,   9'd0,   1'b1, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_CFG, OP_CLEAR, 8'h00, 7'd0,   9'd2,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_PUSH,  8'h81, 7'd0,   9'd0,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_PUSH,  8'h7E, 7'd0,   9'd0,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_PUSH,  8'h33, 7'd0,   9'd0,   1'b1, 1'b0, 9'd0, 9'd2});
    rows.push_back('{ROW_OP,  OP_ALLOC, 8'h00, 7'd1,   9'd0,   1'b1, 1'b0, 9'd0, 9'd2});
    rows.push_back('{ROW_CFG, OP_CLEAR, 8'h00, 7'd0,   9'd1,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_PUSH,  8'h44, 7'd0,   9'd0,   1'b1, 1'b0, 9'd0, 9'd2});
    rows.push_back('{ROW_OP,  OP_ALLOC, 8'h00, 7'd0,   9'd0,   1'b1, 1'b0, 9'd0, 9'd2});
    rows.push_back('{ROW_OP,  OP_POP,   8'h00, 7'd64,  9'd0,   1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_CFG, OP_CLEAR, 8'h00, 7'd0,   9'd511, 1'b0, 1'b0, 9'd0, 9'd0});
    rows.push_back('{ROW_OP,  OP_ALLOC, 8'h00, 7'd64,  9'd0,   1'b1, 1'b1, 9'd0, 9'd64});
    rows.push_back('{ROW_OP,  OP_CLEAR, 8'h00, 7'd0,   9'd0,   1'b1, 1'b0, 9'd0, 9'd0});

    phase_cap  = '{9'd300, 9'd256, 9'd40, 9'd0, 9'd511, 9'd3, 9'd128, 9'd256};
    phase_push = '{70, 75, 50, 40, 60, 50, 55, 50};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_capacity(rows[i].cap);
      end else begin
        if ($urandom_range(0, 3) == 0) sender_gap();
        send_item(rows[i].op, rows[i].data, rows[i].cnt);
        if (rows[i].typed) begin
          typed_beat = '{8'h00, 1'b1, rows[i].ok, rows[i].offset, rows[i].fill};
          awaited_beats[awaited_beats.size() - 1] = typed_beat;
        end
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      if (p == PHASES - 1) quiet = 1'b1;
      phase_items = $urandom_range(24, 28);
      rest = 100 - phase_push[p];
      for (int unsigned i = 0; i < phase_items; i++) begin
        r = $urandom_range(0, 99);
        d = BYTE_W'($urandom);
        c = '0;
        if (r < phase_push[p]) begin
          op = OP_PUSH;
        end else if (r < phase_push[p] + rest * 55 / 100) begin
          op = OP_POP;
          c  = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 127)) :
                                              CNT_W'($urandom_range(0, 16));
          n  = (c < MAX_BLOCK) ? 32'(c) : MAX_BLOCK;
          if (n > stack_fill) n = stack_fill;
          safe = 0;
          while (safe < stack_fill && mem_written[stack_fill - 1 - safe]) safe++;
          // Never pop a byte that an allocate reserved but no push has written.
          if (n > safe) begin
            if (safe == 0 && $urandom_range(0, 1) == 1) op = OP_CLEAR;
            else c = CNT_W'(safe);
          end
        end else if (r < phase_push[p] + rest * 85 / 100) begin
          op = OP_ALLOC;
          c  = ($urandom_range(0, 1) == 0) ? CNT_W'($urandom_range(0, 127)) :
                                              CNT_W'($urandom_range(0, 8));
        end else begin
          op = OP_CLEAR;
        end
        if (!quiet && $urandom_range(0, 3) == 0) sender_gap();
        if (!quiet && $urandom_range(0, 39) == 0) drain();
        send_item(op, d, c);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("byte_stack_allocator_top_tb passed");
    end else begin
      $display("byte_stack_allocator_top_tb failed");
    end
    $finish;
  end

endmodule
